// ----- hdl/tone_divider_step_search_core_assert.svh -----
// Assertion macros for the tone divider step search checker.
// Depends on nothing; included by the checker file.
`ifndef TONE_DIVIDER_STEP_SEARCH_CORE_ASSERT_SVH
`define TONE_DIVIDER_STEP_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define TDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tds_pkg.sv -----
// Shared constants for the tone divider step search block.
// No dependencies; used by the core, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package tds_pkg;
    localparam int CLK_W        = 25;
    localparam int TARGET_W     = 18;
    localparam int DIV_W        = 3;
    localparam int STEP_OUT_W   = 11;
    localparam int SCALE_SH     = 16;
    localparam int DEN_W        = DIV_W + 1;
    localparam int REM_W        = DEN_W + SCALE_SH;
    localparam int ERR_W        = CLK_W - SCALE_SH + 1;
    localparam int DIV_MAX_DEF  = 7;
    localparam int STEP_MAX_DEF = 256;
    localparam logic [CLK_W-1:0] CLK_RESET = 25'd8500000;
endpackage
`default_nettype wire

// ----- hdl/tone_divider_step_search_core.sv -----
// Top level of the tone divider step search; uses tds_pkg and tds_div.
// Finds the divide select and step word closest to a target tone.
`timescale 1ns / 1ps
`default_nettype none
// One target is searched at a time; o_in_ready is high only while idle.
// For each divide select tried, the shared bit-serial divider first splits
// the clock into a whole and a fractional step, with an NW-bit quotient
// (NW = 9 + bits of STEP_MAX), then the step accumulator tests one step
// word per cycle, up to STEP_MAX, and before moving on a decision state and
// another divider run find the next divider's top frequency. An exact hit
// or a cut-off ends the search early. A finished result sits in the output
// register, so the next target can be accepted while it waits.
// The reference clock register takes writes at any cycle; write it only
// between searches.
module tone_divider_step_search_core #(
    parameter int DIV_MAX  = tds_pkg::DIV_MAX_DEF,
    parameter int STEP_MAX = tds_pkg::STEP_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tds_pkg::CLK_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tds_pkg::TARGET_W-1:0]  i_target_hz,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_status,
    output logic [tds_pkg::DIV_W-1:0]          o_clock_divider,
    output logic [tds_pkg::STEP_OUT_W-1:0]     o_freq_step
);
    localparam int CLK_W  = tds_pkg::CLK_W;
    localparam int SH     = tds_pkg::SCALE_SH;
    localparam int SW     = $clog2(STEP_MAX + 1);
    localparam int PW     = CLK_W + SW;
    localparam int NW     = PW - SH;
    localparam int TW     = tds_pkg::TARGET_W;
    localparam int CMPW   = ((NW > TW) ? NW : TW) + 2;
    localparam int EW     = tds_pkg::ERR_W;
    localparam int RW     = tds_pkg::REM_W;
    localparam int DENW   = tds_pkg::DEN_W;
    localparam int DIVW   = tds_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE, S_Q0, S_STEP, S_NEXT, S_TOP, S_DONE
    } t_state;

    t_state          r_state;
    logic [CLK_W-1:0] r_clk;
    logic [TW-1:0]   r_target;
    logic [PW-1:0]   r_top_num;
    logic [EW-1:0]   r_best_err;
    logic [DIVW-1:0] r_best_div;
    logic [SW-1:0]   r_best_step;
    logic            r_found;
    logic [DIVW-1:0] r_div;
    logic [DENW-1:0] r_d;
    logic [SW-1:0]   r_step;
    logic [NW-1:0]   r_q0;
    logic [RW-1:0]   r_r0;
    logic [NW-1:0]   r_f;
    logic [RW-1:0]   r_r;
    logic            r_dv_start;
    logic [NW-1:0]   r_dv_num;
    logic [DENW-1:0] r_dv_den;
    logic            r_o_valid;
    logic            r_o_status;
    logic [DIVW-1:0] r_o_div;
    logic [SW-1:0]   r_o_step;

    logic            dv_done;
    logic [NW-1:0]   dv_quo;
    logic [DENW-1:0] dv_rem;

    logic [RW:0]     sum_r;
    logic [RW:0]     den_full;
    logic            carry;
    logic [RW:0]     n_r_wide;
    logic [NW-1:0]   n_f;
    logic [CMPW-1:0] f_ext;
    logic [CMPW-1:0] t_ext;
    logic [CMPW-1:0] e_ext;
    logic [CMPW-1:0] err;
    logic            over;
    logic            better;
    logic [EW-1:0]   n_best_err;
    logic [DENW-1:0] d_next;
    logic            top_low;

    tds_div #(.NW(NW), .DW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dv_start),
        .i_num   (r_dv_num),
        .i_den   (r_dv_den),
        .o_done  (dv_done),
        .o_quo   (dv_quo),
        .o_rem   (dv_rem)
    );

    assign sum_r    = {1'b0, r_r} + {1'b0, r_r0};
    assign den_full = {1'b0, r_d, {SH{1'b0}}};
    assign carry    = sum_r >= den_full;
    assign n_r_wide = carry ? (sum_r - den_full) : sum_r;
    assign n_f      = r_f + r_q0 + NW'(carry);

    assign f_ext  = CMPW'(r_f);
    assign t_ext  = CMPW'(r_target);
    assign e_ext  = CMPW'(r_best_err);
    assign over   = f_ext > (t_ext + e_ext);
    assign err    = (f_ext >= t_ext) ? (f_ext - t_ext) : (t_ext - f_ext);
    assign better = err < e_ext;
    assign n_best_err = better ? err[EW-1:0] : r_best_err;

    assign d_next  = {1'b0, r_div} + DENW'(2);
    assign top_low = (CMPW'(dv_quo) + e_ext) < t_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clk      <= tds_pkg::CLK_RESET;
            r_dv_start <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_dv_start <= 1'b0;
            if (i_cfg_valid) begin
                r_clk <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_o_valid || i_out_ready)) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_target    <= i_target_hz;
                        r_best_err  <= EW'(r_clk[CLK_W-1:SH]) + EW'(1);
                        r_best_div  <= '0;
                        r_best_step <= '0;
                        r_found     <= 1'b0;
                        r_div       <= '0;
                        r_d         <= DENW'(1);
                        r_top_num   <= PW'(r_clk) * PW'(STEP_MAX);
                        r_dv_num    <= NW'(r_clk[CLK_W-1:SH]);
                        r_dv_den    <= DENW'(1);
                        r_dv_start  <= 1'b1;
                        r_state     <= S_Q0;
                    end
                end
                S_Q0: begin
                    if (dv_done) begin
                        r_q0    <= dv_quo;
                        r_f     <= dv_quo;
                        r_r0    <= {dv_rem, r_clk[SH-1:0]};
                        r_r     <= {dv_rem, r_clk[SH-1:0]};
                        r_step  <= SW'(1);
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (over) begin
                        r_state <= S_NEXT;
                    end else begin
                        if (better) begin
                            r_best_err  <= n_best_err;
                            r_best_div  <= r_div;
                            r_best_step <= r_step;
                            r_found     <= 1'b1;
                        end
                        if (n_best_err == '0) begin
                            r_state <= S_DONE;
                        end else if (r_step == SW'(STEP_MAX)) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_step <= r_step + SW'(1);
                            r_f    <= n_f;
                            r_r    <= n_r_wide[RW-1:0];
                        end
                    end
                end
                S_NEXT: begin
                    if (r_div == DIVW'(DIV_MAX)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_dv_num   <= r_top_num[PW-1:SH];
                        r_dv_den   <= d_next;
                        r_dv_start <= 1'b1;
                        r_state    <= S_TOP;
                    end
                end
                S_TOP: begin
                    if (dv_done) begin
                        if (top_low) begin
                            r_state <= S_DONE;
                        end else begin
                            r_div      <= r_div + DIVW'(1);
                            r_d        <= d_next;
                            r_dv_num   <= NW'(r_clk[CLK_W-1:SH]);
                            r_dv_den   <= d_next;
                            r_dv_start <= 1'b1;
                            r_state    <= S_Q0;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_status <= !r_found;
                        r_o_div    <= r_found ? r_best_div : '0;
                        r_o_step   <= r_found ? r_best_step : '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_clock_divider = r_o_div;
    assign o_freq_step     = tds_pkg::STEP_OUT_W'(r_o_step);
endmodule
`default_nettype wire

// ----- hdl/tds_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; instanced by tone_divider_step_search_core.
`timescale 1ns / 1ps
`default_nettype none
module tds_div #(
    parameter int NW = 18,
    parameter int DW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_r;
    logic [DW-1:0]    r_den;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {r_r, r_q[NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_r    <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_q <= {r_q[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ----- hdl/tds_checker.sv -----
// Port-level checker for tone_divider_step_search_core, bound to the top.
// Uses tds_pkg and the macros in tone_divider_step_search_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tone_divider_step_search_core_assert.svh"
module tds_checker #(
    parameter int DIV_MAX = tds_pkg::DIV_MAX_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_status,
    input wire logic [tds_pkg::DIV_W-1:0]     o_clock_divider,
    input wire logic [tds_pkg::STEP_OUT_W-1:0] o_freq_step
);
    // held result keeps its payload
    `TDS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_clock_divider) && $stable(o_freq_step),
        "result changed before transfer")
    // a search keeps input ready low once a target is taken
    `TDS_ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready,
        "input ready right after a transfer")
    `TDS_ASSERT_NOW(a_not_found_zero, o_out_valid && o_status,
        o_clock_divider == '0 && o_freq_step == '0,
        "not-found result with nonzero pair")
    `TDS_ASSERT_NOW(a_found_pair, o_out_valid && !o_status,
        o_freq_step != '0 && o_clock_divider <= tds_pkg::DIV_W'(DIV_MAX),
        "found result with invalid pair")
endmodule

bind tone_divider_step_search_core tds_checker #(.DIV_MAX(DIV_MAX)) u_tds_checker (.*);
`default_nettype wire

// ----- dv/tb_tone_divider_step_search_core.sv -----
// Self-checking testbench for tone_divider_step_search_core (uses tds_pkg).
// A scoreboard class predicts the best divide select and step word per target;
// directed targets first, then random phases over several reference clocks.
`timescale 1ns / 1ps
module tb_tone_divider_step_search_core;
    localparam int CLK_W        = tds_pkg::CLK_W;
    localparam int TARGET_W     = tds_pkg::TARGET_W;
    localparam int DIV_W        = tds_pkg::DIV_W;
    localparam int STEP_OUT_W   = tds_pkg::STEP_OUT_W;
    localparam int DIV_MAX_DEF  = tds_pkg::DIV_MAX_DEF;
    localparam int STEP_MAX_DEF = tds_pkg::STEP_MAX_DEF;
    localparam logic [CLK_W-1:0] CLK_RESET = tds_pkg::CLK_RESET;

    typedef struct packed {
        logic                  status;
        logic [DIV_W-1:0]      divider;
        logic [STEP_OUT_W-1:0] step;
    } t_tone_pair;

    function automatic longint unsigned tone_freq(input longint unsigned clk_hz,
                                                  input int unsigned dv,
                                                  input int unsigned st);
        return (clk_hz * 64'(st)) / (64'(dv + 1) * 64'd65536);
    endfunction

    class t_tone_search_scoreboard;
        logic [CLK_W-1:0] ref_clock;
        t_tone_pair       expected_q[$];
        int unsigned      errors;

        function new();
            ref_clock = CLK_RESET;
            errors    = 0;
        endfunction

        function void set_ref_clock(input logic [CLK_W-1:0] v);
            ref_clock = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function t_tone_pair best_pair(input logic [TARGET_W-1:0] target);
            longint unsigned best_err, f, err;
            longint          top, low;
            int unsigned     dv, st, best_div, best_step;
            bit              found, done;
            t_tone_pair      r;
            best_err  = (64'(ref_clock) >> 16) + 1;
            best_div  = 0;
            best_step = 0;
            found     = 1'b0;
            done      = 1'b0;
            dv        = 0;
            while (dv <= DIV_MAX_DEF && !done) begin
                for (st = 1; st <= STEP_MAX_DEF; st++) begin
                    f = tone_freq(64'(ref_clock), dv, st);
                    if (f > 64'(target) + best_err) break;
                    err = (f >= 64'(target)) ? f - 64'(target) : 64'(target) - f;
                    if (err < best_err) begin
                        best_err  = err;
                        best_div  = dv;
                        best_step = st;
                        found     = 1'b1;
                    end
                    if (best_err == 0) begin
                        done = 1'b1;
                        break;
                    end
                end
                if (done) break;
                dv++;
                top = longint'(tone_freq(64'(ref_clock), dv, STEP_MAX_DEF));
                low = longint'(64'(target)) - longint'(best_err);
                if (top < low) break;
            end
            if (found) begin
                r.status  = 1'b0;
                r.divider = DIV_W'(best_div);
                r.step    = STEP_OUT_W'(best_step);
            end else begin
                r = '0;
                r.status = 1'b1;
            end
            return r;
        endfunction

        function void note_target(input logic [TARGET_W-1:0] target);
            expected_q.push_back(best_pair(target));
        endfunction

        function void check_result(input logic s, input logic [DIV_W-1:0] d,
                                   input logic [STEP_OUT_W-1:0] st);
            t_tone_pair e;
            if (expected_q.size() == 0) begin
                $error("result transfer with no pending target: status %0d div %0d step %0d",
                       s, d, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (s !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, s);
                errors++;
            end
            if (d !== e.divider) begin
                $error("clock_divider: expected %0d, actual %0d", e.divider, d);
                errors++;
            end
            if (st !== e.step) begin
                $error("freq_step: expected %0d, actual %0d", e.step, st);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CLK_W-1:0]       i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic [TARGET_W-1:0]    i_target_hz = '0;
    logic                   i_out_ready = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_status;
    logic [DIV_W-1:0]       o_clock_divider;
    logic [STEP_OUT_W-1:0]  o_freq_step;

    int unsigned              src_idle_pct = 0;
    int unsigned              sink_stall_pct = 0;
    t_tone_search_scoreboard  sb = new();

    tone_divider_step_search_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_target_hz     (i_target_hz),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_clock_divider (o_clock_divider),
        .o_freq_step     (o_freq_step)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_status, o_clock_divider, o_freq_step);
        end
    end

    task automatic write_ref_clock(input logic [CLK_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_ref_clock(v);
    endtask

    // valid is only dropped when a gap is taken, never in the step it rises
    task automatic send_target(input logic [TARGET_W-1:0] t);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_target_hz <= t;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_target(t);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [TARGET_W-1:0] pick_target(input logic [CLK_W-1:0] clk_hz);
        longint unsigned top, bound, t, t_max;
        t_max = 64'(2 ** TARGET_W - 1);
        top   = tone_freq(64'(clk_hz), 0, STEP_MAX_DEF);
        bound = (64'(clk_hz) >> 16) + 1;
        case ($urandom_range(9)) inside
            [0:3]: t = tone_freq(64'(clk_hz), $urandom_range(DIV_MAX_DEF),
                                 $urandom_range(STEP_MAX_DEF, 1));
            [4:6]: t = 64'($urandom_range(32'(top + bound)));
            7: begin
                t = tone_freq(64'(clk_hz), $urandom_range(DIV_MAX_DEF), STEP_MAX_DEF)
                    + 64'($urandom_range(32'(2 * bound)));
                t = (t > bound) ? t - bound : 0;
            end
            8: t = 64'($urandom_range(300));
            default: t = 64'($urandom_range(2 ** TARGET_W - 1));
        endcase
        if (t > t_max) t = t_max;
        return t[TARGET_W-1:0];
    endfunction

    task automatic run_phase(input logic [CLK_W-1:0] clk_hz, input int unsigned n,
                             input int unsigned src_pct, input int unsigned sink_pct);
        write_ref_clock(clk_hz);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n) send_target(pick_target(clk_hz));
        drain();
    endtask

    initial begin
        longint unsigned clk0, top0, bound0, top7;
        clk0   = 64'(CLK_RESET);
        top0   = tone_freq(clk0, 0, STEP_MAX_DEF);
        bound0 = (clk0 >> 16) + 1;
        top7   = tone_freq(clk0, DIV_MAX_DEF, STEP_MAX_DEF);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, exact hits, step and divider cut-off edges
        send_target('0);
        send_target(TARGET_W'(1));
        send_target('1);
        send_target(TARGET_W'(1 << (TARGET_W - 1)));
        send_target(TARGET_W'(tone_freq(clk0, 0, 1)));
        send_target(TARGET_W'(tone_freq(clk0, DIV_MAX_DEF, 1)));
        send_target(TARGET_W'(top0));
        send_target(TARGET_W'(top0 + bound0 - 1));
        send_target(TARGET_W'(top0 + bound0));
        send_target(TARGET_W'(top0 + bound0 + 1));
        send_target(TARGET_W'(top0 + 300));
        send_target(TARGET_W'(top7));
        send_target(TARGET_W'(top7 - 1));
        send_target(TARGET_W'(top7 + 1));
        send_target(TARGET_W'(tone_freq(clk0, 3, 200)));
        send_target(TARGET_W'(tone_freq(clk0, 1, STEP_MAX_DEF) + bound0 / 2));
        send_target(TARGET_W'(65));
        send_target(TARGET_W'(440));
        send_target(TARGET_W'(12345));
        send_target(TARGET_W'(20000));
        drain();

        run_phase(25'd1000000, 30, 0, 0);
        run_phase(25'd20000000, 30, 72, 0);
        run_phase('1, 20, 0, 72);
        run_phase('0, 15, 19, 19);
        run_phase(CLK_W'($urandom_range(20000000, 1000000)), 25, 19, 19);

        repeat (3000) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tds_pkg.sv
hdl/tds_div.sv
hdl/tone_divider_step_search_core.sv
hdl/tds_checker.sv
dv/tb_tone_divider_step_search_core.sv
